[rtl/lif_pkg.sv]
// shared types and constants of the leaky integrate-and-fire neuron
// register indexes, reset values, field widths and the config struct
// depends on nothing
package lif_pkg;

  // default widths of the voltage state and the sample counter
  localparam int VOLT_WIDTH_DEF  = 24;
  localparam int INDEX_WIDTH_DEF = 32;

  // fixed field widths
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;
  localparam int RATE_W    = 16;
  localparam int MODE_W    = 2;
  localparam int DRIVE_W   = 24;
  localparam int NOISE_W   = 16;
  localparam int MEMB_W    = 24;
  localparam int CNT_OUT_W = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 88;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_PEAK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE = 3'd7;

  // output modes; the unused fourth code acts as spike indices only
  localparam logic [MODE_W-1:0] MODE_FLAGS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRACE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EVENTS = 2'd2;

  // register reset values
  localparam logic [RATE_W-1:0]        LEAK_RATE_RST   = 16'd655;
  localparam logic signed [CFG_W-1:0]  REST_LEVEL_RST  = -24'sd17920;
  localparam logic signed [CFG_W-1:0]  SPIKE_PEAK_RST  = 24'sd10240;
  localparam logic signed [CFG_W-1:0]  RESET_LEVEL_RST = -24'sd17920;
  localparam logic signed [CFG_W-1:0]  THRESHOLD_RST   = -24'sd12800;
  localparam logic [RATE_W-1:0]        NOISE_GAIN_RST  = 16'd0;
  localparam logic [RATE_W-1:0]        REFRACTORY_RST  = 16'd0;
  localparam logic [MODE_W-1:0]        OUTPUT_MODE_RST = MODE_FLAGS;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [RATE_W-1:0]       leak_rate;
    logic signed [CFG_W-1:0] rest_level;
    logic signed [CFG_W-1:0] spike_peak;
    logic signed [CFG_W-1:0] reset_level;
    logic signed [CFG_W-1:0] threshold;
    logic [RATE_W-1:0]       noise_gain;
    logic [RATE_W-1:0]       refractory_samples;
    logic [MODE_W-1:0]       output_mode;
  } lif_cfg_t;

endpackage

[rtl/lif_cfg.sv]
// configuration register file of the neuron
// decodes writes on the cfg channel into lif_cfg_t
// depends on lif_pkg
module lif_cfg
  import lif_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output lif_cfg_t             cfg
);

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg.leak_rate          <= LEAK_RATE_RST;
      cfg.rest_level         <= REST_LEVEL_RST;
      cfg.spike_peak         <= SPIKE_PEAK_RST;
      cfg.reset_level        <= RESET_LEVEL_RST;
      cfg.threshold          <= THRESHOLD_RST;
      cfg.noise_gain         <= NOISE_GAIN_RST;
      cfg.refractory_samples <= REFRACTORY_RST;
      cfg.output_mode        <= OUTPUT_MODE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEAK_RATE:   cfg.leak_rate          <= cfg_data[RATE_W-1:0];
        CFG_REST_LEVEL:  cfg.rest_level         <= $signed(cfg_data);
        CFG_SPIKE_PEAK:  cfg.spike_peak         <= $signed(cfg_data);
        CFG_RESET_LEVEL: cfg.reset_level        <= $signed(cfg_data);
        CFG_THRESHOLD:   cfg.threshold          <= $signed(cfg_data);
        CFG_NOISE_GAIN:  cfg.noise_gain         <= cfg_data[RATE_W-1:0];
        CFG_REFRACTORY:  cfg.refractory_samples <= cfg_data[RATE_W-1:0];
        CFG_OUTPUT_MODE: cfg.output_mode        <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/lif_mul.sv]
// shared registered multiplier of the neuron datapath
// unsigned 16-bit coefficient, carried as 17-bit signed, times a signed operand
// depends on lif_pkg
module lif_mul
  import lif_pkg::*;
#(
  parameter int B_W = 27
)
(
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [RATE_W:0]       a,
  input  logic signed [B_W-1:0]        b,
  output logic signed [RATE_W+B_W:0]   p_r
);

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

endmodule

[rtl/leaky_integrate_fire_neuron_top.sv]
// leaky integrate-and-fire neuron: one Euler step per item on one shared multiplier
// states: an integrating item runs MUL1, SUM, MUL2 and UPD; the first item and the
// item after a spike go straight to UPD (no integration); UPD waits for a free output.
// A new item is taken only in IDLE, after UPD is done; the single multiplier is
// used twice per integrating item (noise scaling, then leak step) with a sum between
// reset (rst_n low, synchronous): registers to defaults, voltage to rest level,
// counters and refractory state cleared, output empty
module leaky_integrate_fire_neuron_top
  import lif_pkg::*;
#(
  parameter int VOLT_WIDTH  = VOLT_WIDTH_DEF,
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // config write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // drive_current[23:0], noise_sample[39:24]
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // membrane[23:0], spike_index[55:24],
                                            // spike_total[87:56]
  output logic                  out_tuser   // spike
);

  localparam int VW  = VOLT_WIDTH;
  localparam int IW  = INDEX_WIDTH;
  localparam int EW  = (VW > CFG_W) ? VW : CFG_W;
  localparam int SW  = EW + 3;
  localparam int SRW = (SW >= 48) ? 48 : SW;
  localparam int PW  = RATE_W + 1 + SRW;
  localparam int DW  = PW - 15;
  localparam int NW  = DW + 1;
  localparam int IXW = (IW > CNT_OUT_W) ? IW : CNT_OUT_W;
  localparam int AW  = ((IW > RATE_W) ? IW : RATE_W) + 1;
  localparam int NTW = 22;

  localparam logic [IW-1:0]  IDX_MAX = '1;
  localparam logic [CNT_OUT_W-1:0] TOTAL_MAX = '1;
  localparam logic signed [PW:0]  ROUND_D = (PW+1)'(32768);
  localparam logic signed [NTW+11:0] ROUND_N = (NTW+12)'(2048);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  // saturation helpers
  function automatic logic signed [VW-1:0] sat_ew(input logic signed [EW-1:0] x);
    logic ok;
    ok = (&x[EW-1:VW-1]) | ~(|x[EW-1:VW-1]);
    if (ok) return x[VW-1:0];
    return x[EW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  endfunction

  function automatic logic signed [VW-1:0] sat_nw(input logic signed [NW-1:0] x);
    logic ok;
    ok = (&x[NW-1:VW-1]) | ~(|x[NW-1:VW-1]);
    if (ok) return x[VW-1:0];
    return x[NW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  endfunction

  function automatic logic signed [MEMB_W-1:0] sat_out(input logic signed [EW-1:0] x);
    logic ok;
    ok = (&x[EW-1:MEMB_W-1]) | ~(|x[EW-1:MEMB_W-1]);
    if (ok) return x[MEMB_W-1:0];
    return x[EW-1] ? {1'b1, {(MEMB_W-1){1'b0}}} : {1'b0, {(MEMB_W-1){1'b1}}};
  endfunction

  lif_cfg_t cfg;

  logic [2:0]                    state_r, state_nxt;
  logic signed [DRIVE_W-1:0]     drive_r;
  logic signed [NOISE_W-1:0]     noise_r;
  logic signed [VW-1:0]          volt_r, volt_nxt;
  logic [IW-1:0]                 cnt_r, cnt_nxt;
  logic [IW-1:0]                 next_ok_r, next_ok_nxt;
  logic                          skip_r, skip_nxt;
  logic [CNT_OUT_W-1:0]          spike_cnt_r, spike_cnt_nxt;
  logic signed [SRW-1:0]         sum_r;
  logic                          out_valid_r;
  logic signed [MEMB_W-1:0]      memb_r;
  logic                          spike_r;
  logic [CNT_OUT_W-1:0]          index_r;
  logic [CNT_OUT_W-1:0]          total_r;

  logic                          in_acc;
  logic                          out_free;
  logic                          upd_go;
  logic                          mul_en;
  logic signed [RATE_W:0]        mul_a;
  logic signed [SRW-1:0]         mul_b;
  logic signed [PW-1:0]          prod_r;

  logic signed [VW-1:0]          rest_v, peak_v, reset_v, thr_v;
  logic signed [NTW+11:0]        nprod;
  logic signed [NTW-1:0]         nterm;
  logic signed [SW-1:0]          sum_full;
  logic signed [SRW-1:0]         sum_c;
  logic signed [PW:0]            dprod;
  logic signed [DW-1:0]          delta;
  logic signed [NW-1:0]          vsum;
  logic signed [VW-1:0]          vi;
  logic                          fire_c;
  logic                          emit_c;
  logic signed [VW-1:0]          shown_c;
  logic [AW-1:0]                 na_sum;
  logic [IXW-1:0]                idx_ext;

  // configuration registers
  lif_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshakes
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign upd_go    = (state_r == ST_UPD) & out_free;

  // shared multiplier: noise gain first, then leak rate
  assign mul_en = (state_r == ST_MUL1) | (state_r == ST_MUL2);
  assign mul_a  = (state_r == ST_MUL1) ? $signed({1'b0, cfg.noise_gain})
                                       : $signed({1'b0, cfg.leak_rate});
  assign mul_b  = (state_r == ST_MUL1) ? SRW'(noise_r) : sum_r;

  lif_mul #(.B_W(SRW)) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  // register values brought to the voltage width
  assign rest_v  = sat_ew(EW'(cfg.rest_level));
  assign peak_v  = sat_ew(EW'(cfg.spike_peak));
  assign reset_v = sat_ew(EW'(cfg.reset_level));
  assign thr_v   = sat_ew(EW'(cfg.threshold));

  // rounded noise term and drive sum
  assign nprod    = $signed(prod_r[NTW+11:0]) + ROUND_N;
  assign nterm    = nprod[NTW+11:12];
  assign sum_full = SW'(cfg.rest_level) - SW'(volt_r) + SW'(nterm) + SW'(drive_r);

  generate
    if (SW >= 48) begin : g_clamp
      localparam logic signed [SW-1:0] LIM_HI = SW'(64'sd70368744177664);
      localparam logic signed [SW-1:0] LIM_LO = -LIM_HI;
      always_comb begin
        if (sum_full > LIM_HI) begin
          sum_c = SRW'(LIM_HI);
        end else if (sum_full < LIM_LO) begin
          sum_c = SRW'(LIM_LO);
        end else begin
          sum_c = SRW'(sum_full);
        end
      end
    end else begin : g_noclamp
      assign sum_c = sum_full;
    end
  endgenerate

  // leak step and new voltage
  assign dprod = (PW+1)'(prod_r) + ROUND_D;
  assign delta = dprod[PW:16];
  assign vsum  = NW'(volt_r) + NW'(delta);
  assign vi    = sat_nw(vsum);

  // saturating sample index and refractory bound
  assign cnt_nxt = (cnt_r == IDX_MAX) ? cnt_r : cnt_r + IW'(1);
  assign idx_ext = IXW'(cnt_nxt);
  assign na_sum  = AW'(cnt_r) + AW'(cfg.refractory_samples);

  // update decision
  always_comb begin
    volt_nxt      = volt_r;
    next_ok_nxt   = next_ok_r;
    skip_nxt      = skip_r;
    spike_cnt_nxt = spike_cnt_r;
    fire_c        = 1'b0;
    shown_c       = volt_r;
    if (cnt_r == '0) begin
      // first sample loads the rest level
      volt_nxt = rest_v;
      shown_c  = rest_v;
    end else if (skip_r) begin
      // sample after a spike holds the reset level
      skip_nxt = 1'b0;
    end else if (vi >= thr_v) begin
      if (cnt_r >= next_ok_r) begin
        fire_c      = 1'b1;
        next_ok_nxt = (na_sum >= AW'(IDX_MAX)) ? IDX_MAX : na_sum[IW-1:0];
        if (spike_cnt_r != TOTAL_MAX) begin
          spike_cnt_nxt = spike_cnt_r + CNT_OUT_W'(1);
        end
        shown_c  = peak_v;
        volt_nxt = reset_v;
        skip_nxt = 1'b1;
      end else begin
        // inside the refractory gap: clamp at threshold
        volt_nxt = thr_v;
        shown_c  = thr_v;
      end
    end else begin
      volt_nxt = vi;
      shown_c  = vi;
    end
    emit_c = ~(cfg.output_mode >= MODE_EVENTS) | fire_c;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) begin
        state_nxt = ((cnt_r == '0) || skip_r) ? ST_UPD : ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_UPD;
      ST_UPD:  if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and neuron state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      volt_r      <= sat_ew(EW'(REST_LEVEL_RST));
      cnt_r       <= '0;
      next_ok_r   <= '0;
      skip_r      <= 1'b0;
      spike_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        volt_r      <= volt_nxt;
        cnt_r       <= cnt_nxt;
        next_ok_r   <= next_ok_nxt;
        skip_r      <= skip_nxt;
        spike_cnt_r <= spike_cnt_nxt;
      end
      if (upd_go && emit_c) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      drive_r <= $signed(in_tdata[DRIVE_W-1:0]);
      noise_r <= $signed(in_tdata[DRIVE_W+NOISE_W-1:DRIVE_W]);
    end
    if (state_r == ST_SUM) begin
      sum_r <= sum_c;
    end
    if (upd_go && emit_c) begin
      memb_r  <= sat_out(EW'(shown_c));
      spike_r <= fire_c;
      index_r <= idx_ext[CNT_OUT_W-1:0];
      total_r <= spike_cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {total_r, index_r, memb_r};
  assign out_tuser  = spike_r;

  // no new item right after one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken again while busy");

  // in spike index mode every result is a spike
  a_events_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (cfg.output_mode >= MODE_EVENTS)) |-> out_tuser)
    else $error("non-spike result in spike index mode");

  // spike counter advances on a firing update
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && fire_c && (spike_cnt_r != TOTAL_MAX))
      |=> (spike_cnt_r == $past(spike_cnt_r) + CNT_OUT_W'(1)))
    else $error("spike counter did not advance");

  // voltage drops to the reset level on a spike
  a_reset_after_spike: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skip_r) |-> (volt_r == reset_v))
    else $error("voltage not at reset level after spike");

endmodule

[dv/testbench.sv]
// self-checking testbench for leaky_integrate_fire_neuron_top
// predicts every item with a fixed-point copy of the neuron and checks results in order
// depends on rtl/lif_pkg.sv and rtl/leaky_integrate_fire_neuron_top.sv
`timescale 1ns / 100ps

module testbench;
  import lif_pkg::*;

  localparam int    CYCLE_LIMIT   = 500000;
  localparam int    SETTLE_CYCLES = 12;
  localparam int    HOLD_CYCLES   = 400;
  localparam int    MAX_REPORTS   = 10;
  localparam longint VOLT_MAX     = 64'sd8388607;
  localparam longint VOLT_MIN     = -64'sd8388608;
  localparam longint SUM_LIMIT    = 64'sd1 << 46;
  localparam longint COUNT_MAX    = 64'sh0000_0000_FFFF_FFFF;
  // the fourth mode code behaves like spike indices only
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MEMB_W-1:0]    membrane;
    logic                 spike;
    logic [CNT_OUT_W-1:0] index;
    logic [CNT_OUT_W-1:0] total;
  } neuron_result_t;

  // fixed-point neuron copy plus the queue of results it still expects
  class neuron_scoreboard;
    longint rate, rest, peak, rst_lvl, thresh, gain, refr;
    logic [MODE_W-1:0] mode;
    longint volt, samples, earliest_fire, fired_count;
    bit hold_after_spike;
    neuron_result_t pending_results[$];
    int mismatches;
    int results_seen;

    function new();
      rate = LEAK_RATE_RST;
      rest = REST_LEVEL_RST;
      peak = SPIKE_PEAK_RST;
      rst_lvl = RESET_LEVEL_RST;
      thresh = THRESHOLD_RST;
      gain = NOISE_GAIN_RST;
      refr = REFRACTORY_RST;
      mode = OUTPUT_MODE_RST;
      volt = sat_volt(rest);
      samples = 0;
      earliest_fire = 0;
      fired_count = 0;
      hold_after_spike = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function longint sat_volt(longint x);
      if (x > VOLT_MAX) return VOLT_MAX;
      if (x < VOLT_MIN) return VOLT_MIN;
      return x;
    endfunction

    function longint sat_count_add(longint a, longint b);
      if (a >= COUNT_MAX || b >= COUNT_MAX - a) return COUNT_MAX;
      return a + b;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_LEAK_RATE:   rate = val[RATE_W-1:0];
        CFG_REST_LEVEL:  rest = longint'($signed(val));
        CFG_SPIKE_PEAK:  peak = longint'($signed(val));
        CFG_RESET_LEVEL: rst_lvl = longint'($signed(val));
        CFG_THRESHOLD:   thresh = longint'($signed(val));
        CFG_NOISE_GAIN:  gain = val[RATE_W-1:0];
        CFG_REFRACTORY:  refr = val[RATE_W-1:0];
        CFG_OUTPUT_MODE: mode = val[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    // one euler step of the membrane; queues the result if the mode emits one
    function void note_sample(logic [IN_DATA_W-1:0] data);
      longint drv, nz, nterm, sum, step, vn, shown, ti;
      bit fired;
      neuron_result_t r;
      drv = longint'($signed(data[DRIVE_W-1:0]));
      nz = longint'($signed(data[DRIVE_W+NOISE_W-1:DRIVE_W]));
      ti = samples;
      fired = 0;
      if (ti == 0) begin
        // very first sample only loads the rest level
        volt = sat_volt(rest);
        shown = volt;
      end else if (hold_after_spike) begin
        // sample after a spike is taken without integrating
        hold_after_spike = 0;
        shown = volt;
      end else begin
        nterm = (gain * nz + 2048) >>> 12;
        sum = rest - volt + nterm + drv;
        if (sum > SUM_LIMIT) sum = SUM_LIMIT;
        else if (sum < -SUM_LIMIT) sum = -SUM_LIMIT;
        step = (rate * sum + 32768) >>> 16;
        vn = sat_volt(volt + step);
        if (vn >= thresh && ti >= earliest_fire) begin
          fired = 1;
          earliest_fire = sat_count_add(ti, refr);
          if (fired_count < COUNT_MAX) fired_count++;
          shown = sat_volt(peak);
          volt = sat_volt(rst_lvl);
          hold_after_spike = 1;
        end else if (vn >= thresh) begin
          // inside the refractory gap the voltage is clamped at threshold
          volt = sat_volt(thresh);
          shown = volt;
        end else begin
          volt = vn;
          shown = vn;
        end
      end
      if (samples < COUNT_MAX) samples++;
      if (mode >= MODE_EVENTS && !fired) return;
      r.membrane = shown[MEMB_W-1:0];
      r.spike = fired;
      r.index = sat_count_add(ti, 1) & COUNT_MAX;
      r.total = fired_count & COUNT_MAX;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic spike);
      neuron_result_t got, want;
      got.membrane = data[23:0];
      got.index = data[55:24];
      got.total = data[87:56];
      got.spike = spike;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d arrived with nothing expected: membrane %0d index %0d",
                   results_seen, $signed(got.membrane), got.index);
        return;
      end
      want = pending_results.pop_front();
      if (got.membrane !== want.membrane || got.spike !== want.spike ||
          got.index !== want.index || got.total !== want.total) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d expected membrane %0d spike %0b index %0d total %0d",
                   results_seen, $signed(want.membrane), want.spike, want.index, want.total);
          $display("result %0d got      membrane %0d spike %0b index %0d total %0d",
                   results_seen, $signed(got.membrane), got.spike, got.index, got.total);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // drive_current[23:0], noise_sample[39:24]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // membrane[23:0], spike_index[55:24],
                                          // spike_total[87:56]
  logic                  out_tuser;       // spike

  neuron_scoreboard sb;
  int     tx_quiet = 0;
  int     rx_quiet = 0;
  bit     hold_request = 0;
  int     cycle_count = 0;
  longint drive_lo = -2560;
  longint drive_hi = 25600;

  leaky_integrate_fire_neuron_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // idle lengths: mostly none or short, a few long, with quiet streaks of no idling
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic logic [DRIVE_W-1:0] rand_drive();
    case ($urandom_range(0, 15))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return 24'($urandom);
      default: return 24'(drive_lo + longint'($urandom_range(0, 32'(drive_hi - drive_lo))));
    endcase
  endfunction

  function automatic logic [NOISE_W-1:0] rand_noise();
    case ($urandom_range(0, 15))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.load_register(idx, val);
  endtask

  // unused upper bits of narrow registers carry random junk
  task automatic configure(input longint rate, rest, peak, rst_lvl, thr, gain, refr,
                           input logic [MODE_W-1:0] mode);
    write_register(CFG_LEAK_RATE,   {8'($urandom), rate[15:0]});
    write_register(CFG_REST_LEVEL,  rest[23:0]);
    write_register(CFG_SPIKE_PEAK,  peak[23:0]);
    write_register(CFG_RESET_LEVEL, rst_lvl[23:0]);
    write_register(CFG_THRESHOLD,   thr[23:0]);
    write_register(CFG_NOISE_GAIN,  {8'($urandom), gain[15:0]});
    write_register(CFG_REFRACTORY,  {8'($urandom), refr[15:0]});
    write_register(CFG_OUTPUT_MODE, {22'($urandom), mode});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [DRIVE_W-1:0] drive, input logic [NOISE_W-1:0] noise);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {noise, drive};
    do @(posedge clk); while (!in_tready);
    sb.note_sample({noise, drive});
  endtask

  // random items; spike-only modes keep going until 40 more spikes are predicted, up to 4 times the count
  task automatic run_random(input int count);
    int n;
    longint start_spikes;
    n = 0;
    start_spikes = sb.fired_count;
    while (n < count || (sb.mode >= MODE_EVENTS && sb.fired_count - start_spikes < 40 &&
                         n < 4 * count)) begin
      send_item(rand_drive(), rand_noise());
      n++;
    end
  endtask

  // wait until every expected result is out, then let any silent item finish
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result sink with random stalls and one long hold-off on request
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 0;
      end else begin
        stall = pick_gap(rx_quiet);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    longint base, span;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: first sample, spike, sample after spike, field extremes
    send_item(24'd0, 16'd0);
    send_item(24'h7FFFFF, 16'h7FFF);
    send_item(24'h800000, 16'h8000);
    send_item(24'h800000, 16'h8000);
    send_item(24'h7FFFFF, 16'h0000);
    send_item(24'h000100, 16'h8000);
    send_item(24'hFFFF00, 16'h7FFF);
    send_item(24'h7FFFFF, 16'h7FFF);
    run_random(120);
    drain();

    // extreme rate and gain, threshold at the top, trace mode with a long receiver hold-off
    configure(65535, 0, 8388607, -8388608, 8388607, 65535, 0, MODE_TRACE);
    send_item(24'h7FFFFF, 16'h7FFF);
    send_item(24'h000000, 16'h0000);
    send_item(24'h800000, 16'h8000);
    send_item(24'h7FFFFF, 16'h7FFF);
    send_item(24'h000000, 16'h0000);
    hold_request = 1;
    drive_lo = -1048576;
    drive_hi = 1048576;
    run_random(150);
    drain();

    // strong drive right after a spike hits threshold inside the refractory gap
    configure(8000, -17920, 10240, -19200, -12800, 256, 4, MODE_TRACE);
    repeat (6) send_item(24'd51200, 16'd0);
    drive_lo = -5120;
    drive_hi = 25600;
    run_random(150);
    drain();

    configure(12000, -17920, 10240, -17920, -12800, 512, 2, MODE_EVENTS);
    drive_lo = 0;
    drive_hi = 20000;
    run_random(150);
    drain();

    configure(20000, 2560, -2560, 0, 7680, 128, 0, MODE_UNUSED);
    drive_lo = -2560;
    drive_hi = 15360;
    run_random(150);
    drain();

    // random settings around a random rest level
    for (int k = 0; k < 4; k++) begin
      base = longint'($urandom_range(0, 131072)) - 65536;
      span = $urandom_range(256, 16384);
      drive_lo = -(span / 2);
      drive_hi = 3 * span;
      configure($urandom_range(500, 20000), base, longint'($signed(24'($urandom))),
                base - longint'($urandom_range(0, 4096)), base + span,
                $urandom_range(0, 1024), $urandom_range(0, 8), 2'($urandom_range(0, 3)));
      run_random(120);
      drain();
    end

    // frozen voltage, lowest threshold and longest gap: one spike, then clamping
    configure(0, -8388608, -8388608, 8388607, -8388608, 0, 65535, MODE_FLAGS);
    run_random(60);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
